[rtl/l1_nearest_neighbor_classifier_unit_assert.svh]
// Assertion macros shared by the checker of the L1 nearest neighbor unit.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef L1_NEAREST_NEIGHBOR_CLASSIFIER_UNIT_ASSERT_SVH
`define L1_NEAREST_NEIGHBOR_CLASSIFIER_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define L1NN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define L1NN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/l1nn_pkg.sv]
// Shared types and constants of the L1 nearest neighbor classifier.
// No dependencies; the cell, best, top and checker files refer to this package.
package l1nn_pkg;

  // Default values of the top level parameters.
  localparam int CAPACITY_DEF    = 256;
  localparam int MAX_DIMS_DEF    = 8;
  localparam int COORD_BITS_DEF  = 16;
  localparam int CLASS_COUNT_DEF = 256;

  // Fixed field widths of the transfer payloads.
  localparam int NUM_COORDS  = 8;
  localparam int OP_W        = 2;
  localparam int CLASS_W     = 8;
  localparam int CLASS_CODES = 2 ** CLASS_W;
  localparam int FIELD_W     = 16;
  localparam int DIST_W      = 19;
  localparam int unsigned DIST_MAX = 524287;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ADD      = 2'd0;
  localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int DIMS_W  = 4;
  localparam logic [DIMS_W-1:0] DIMS_RESET = 4'd8;
  localparam logic [PADDR_W-3:0] REG_DIMS  = '0;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic [CLASS_W-1:0]        class_id;
    logic signed [FIELD_W-1:0] coord_0;
    logic signed [FIELD_W-1:0] coord_1;
    logic signed [FIELD_W-1:0] coord_2;
    logic signed [FIELD_W-1:0] coord_3;
    logic signed [FIELD_W-1:0] coord_4;
    logic signed [FIELD_W-1:0] coord_5;
    logic signed [FIELD_W-1:0] coord_6;
    logic signed [FIELD_W-1:0] coord_7;
  } in_item_t;

  typedef struct packed {
    logic [CLASS_W-1:0] best_class;
    logic               match_found;
    logic [DIST_W-1:0]  best_distance;
    logic               store_full;
  } out_item_t;

  // Control that travels along the distance chain with each entry.
  typedef struct packed {
    logic valid;
    logic last;
  } chain_ctl_t;

  // Status of the running minimum search.
  typedef struct packed {
    logic done;
    logic match;
  } best_status_t;

endpackage

[rtl/l1nn_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module l1nn_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/l1nn_cell.sv]
// One coordinate cell of the distance chain: holds one coordinate of every entry,
// adds its absolute difference to the running sum. Uses l1nn_pkg and l1nn_ram.
module l1nn_cell #(
  parameter int COORD_BITS = 16,
  parameter int CAPACITY   = 256,
  parameter int ADDR_W     = 8,
  parameter int SUM_W      = 19
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr_en,
  input  logic [ADDR_W-1:0]      wr_addr,
  input  logic [COORD_BITS-1:0]  wr_data,
  input  logic [COORD_BITS-1:0]  q,
  input  logic                   dim_en,
  input  l1nn_pkg::chain_ctl_t   ctl_i,
  input  logic [ADDR_W-1:0]      addr_i,
  input  logic [SUM_W-1:0]       sum_i,
  output l1nn_pkg::chain_ctl_t   ctl_o,
  output logic [ADDR_W-1:0]      addr_o,
  output logic [SUM_W-1:0]       sum_o
);

  logic [COORD_BITS-1:0] rd_data;
  l1nn_pkg::chain_ctl_t  ctl_a_r, ctl_o_r;
  logic [ADDR_W-1:0]     addr_a_r, addr_o_r;
  logic [SUM_W-1:0]      sum_a_r, sum_o_r, sum_o_nxt;
  logic signed [COORD_BITS:0] diff, neg_diff;
  logic [COORD_BITS-1:0] abs_diff;

  l1nn_ram #(
    .WIDTH (COORD_BITS),
    .DEPTH (CAPACITY),
    .ADDR_W(ADDR_W)
  ) u_coord_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (ctl_i.valid),
    .raddr(addr_i),
    .rdata(rd_data)
  );

  always_comb begin
    diff     = $signed({rd_data[COORD_BITS-1], rd_data}) - $signed({q[COORD_BITS-1], q});
    neg_diff = -diff;
    abs_diff = diff[COORD_BITS] ? neg_diff[COORD_BITS-1:0] : diff[COORD_BITS-1:0];
    sum_o_nxt = sum_a_r + (dim_en ? SUM_W'(abs_diff) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_o_r <= '0;
    end else begin
      ctl_a_r <= ctl_i;
      ctl_o_r <= ctl_a_r;
    end
  end

  always_ff @(posedge clk) begin
    addr_a_r <= addr_i;
    sum_a_r  <= sum_i;
    addr_o_r <= addr_a_r;
    sum_o_r  <= sum_o_nxt;
  end

  assign ctl_o  = ctl_o_r;
  assign addr_o = addr_o_r;
  assign sum_o  = sum_o_r;

endmodule

[rtl/l1nn_best.sv]
// End of the distance chain: label store, saturation and running minimum search
// with tie break on the smaller class. Uses l1nn_pkg and l1nn_ram.
module l1nn_best #(
  parameter int CAPACITY = 256,
  parameter int ADDR_W   = 8,
  parameter int SUM_W    = 19,
  parameter int LABEL_W  = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [LABEL_W-1:0]         wr_label,
  input  l1nn_pkg::chain_ctl_t       ctl_i,
  input  logic [ADDR_W-1:0]          addr_i,
  input  logic [SUM_W-1:0]           sum_i,
  output l1nn_pkg::best_status_t     status_o,
  output logic [LABEL_W-1:0]         best_class_o,
  output logic [l1nn_pkg::DIST_W-1:0] best_dist_o
);

  localparam int DW = l1nn_pkg::DIST_W;

  logic [LABEL_W-1:0]   label_rd;
  l1nn_pkg::chain_ctl_t ctl_b_r;
  logic [DW-1:0]        dist_b_r, dist_sat;
  logic                 match_r, done_r, better;
  logic [DW-1:0]        best_dist_r;
  logic [LABEL_W-1:0]   best_cls_r;

  l1nn_ram #(
    .WIDTH (LABEL_W),
    .DEPTH (CAPACITY),
    .ADDR_W(ADDR_W)
  ) u_label_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_label),
    .re   (ctl_i.valid),
    .raddr(addr_i),
    .rdata(label_rd)
  );

  always_comb begin
    dist_sat = (sum_i > SUM_W'(l1nn_pkg::DIST_MAX)) ? DW'(l1nn_pkg::DIST_MAX) : DW'(sum_i);
    // Entries arrive in store order, so a strict compare keeps the earlier
    // entry when both distance and class are equal.
    better = !match_r || (dist_b_r < best_dist_r) ||
             ((dist_b_r == best_dist_r) && (label_rd < best_cls_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_b_r <= '0;
      match_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      ctl_b_r <= ctl_i;
      done_r  <= ctl_b_r.valid & ctl_b_r.last;
      if (start) begin
        match_r <= 1'b0;
      end else if (ctl_b_r.valid && better) begin
        match_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dist_b_r <= dist_sat;
    if (start) begin
      best_dist_r <= '0;
      best_cls_r  <= '0;
    end else if (ctl_b_r.valid && better) begin
      best_dist_r <= dist_b_r;
      best_cls_r  <= label_rd;
    end
  end

  assign status_o.done  = done_r;
  assign status_o.match = match_r;
  assign best_class_o   = best_cls_r;
  assign best_dist_o    = best_dist_r;

endmodule

[rtl/l1_nearest_neighbor_classifier_unit.sv]
// Top level of the L1 nearest neighbor classifier: control, configuration
// register and the chain of coordinate cells. Uses l1nn_pkg, l1nn_cell, l1nn_best.
//
// Usage. Items arrive on the in_ channel (valid/ready) as an in_item_t; every
// accepted item produces exactly one out_item_t transfer on the out_ channel.
// An add stores the point at the next free entry (or raises store_full when the
// store is full), a clear empties the store, and a classify returns the class
// and L1 distance of the nearest stored entry over the first dims_in_use
// coordinates. dims_in_use sits at byte address 0 of the APB-style port.
// Add, clear and unused codes pass through the done state and then into the
// output register. A classify feeds the N stored entries into the cell chain,
// one entry per cycle; each cell adds two register stages, and the minimum
// search adds two more. One item is in work at a time; the next transfer is
// taken once the result is in the output register, so classify throughput is
// bounded by the store walk.
// Reset empties the store and sets dims_in_use to 8; the stored points
// themselves are not cleared, since only entries below the fill count are read.
// A stalled receiver holds the result in the output register; the block then
// takes one more item, works it and waits with that result until the register
// is free.
module l1_nearest_neighbor_classifier_unit #(
  parameter int CAPACITY    = l1nn_pkg::CAPACITY_DEF,
  parameter int MAX_DIMS    = l1nn_pkg::MAX_DIMS_DEF,
  parameter int COORD_BITS  = l1nn_pkg::COORD_BITS_DEF,
  parameter int CLASS_COUNT = l1nn_pkg::CLASS_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  l1nn_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output l1nn_pkg::out_item_t            out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [l1nn_pkg::PADDR_W-1:0]   paddr,
  input  logic [l1nn_pkg::PDATA_W-1:0]   pwdata,
  output logic [l1nn_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int SUM_W     = COORD_BITS + $clog2(MAX_DIMS);
  localparam int CLS_RANGE = (CLASS_COUNT < l1nn_pkg::CLASS_CODES) ?
                             CLASS_COUNT : l1nn_pkg::CLASS_CODES;
  localparam int LABEL_W   = $clog2(CLS_RANGE);
  localparam int DIMS_W    = l1nn_pkg::DIMS_W;
  localparam int CW        = l1nn_pkg::CLASS_W;
  localparam int PDW       = l1nn_pkg::PDATA_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [ADDR_W-1:0]           scan_addr_r, scan_addr_nxt;
  logic [l1nn_pkg::OP_W-1:0]   op_r, op_nxt;
  logic                        full_r, full_nxt;
  logic [DIMS_W-1:0]           dims_r, dims_act;
  l1nn_pkg::out_item_t         out_r, out_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        in_acc, out_load, wr_en, start, scan_last;

  logic signed [l1nn_pkg::FIELD_W-1:0] in_coord [l1nn_pkg::NUM_COORDS];
  logic [COORD_BITS-1:0]       coord_cvt [MAX_DIMS];
  logic [COORD_BITS-1:0]       q_r [MAX_DIMS];
  logic [MAX_DIMS-1:0]         dim_en;
  logic [LABEL_W-1:0]          cls_tbl [l1nn_pkg::CLASS_CODES];
  logic [LABEL_W-1:0]          wr_label;

  l1nn_pkg::chain_ctl_t        ctl_ch  [MAX_DIMS+1];
  logic [ADDR_W-1:0]           addr_ch [MAX_DIMS+1];
  logic [SUM_W-1:0]            sum_ch  [MAX_DIMS+1];

  l1nn_pkg::best_status_t      best_st;
  logic [LABEL_W-1:0]          best_cls;
  logic [l1nn_pkg::DIST_W-1:0] best_dist;

  logic                        cfg_wr;
  logic [l1nn_pkg::PADDR_W-3:0] reg_idx;

  // Coordinate fields as an array, one per cell.
  assign in_coord[0] = in_data.coord_0;
  assign in_coord[1] = in_data.coord_1;
  assign in_coord[2] = in_data.coord_2;
  assign in_coord[3] = in_data.coord_3;
  assign in_coord[4] = in_data.coord_4;
  assign in_coord[5] = in_data.coord_5;
  assign in_coord[6] = in_data.coord_6;
  assign in_coord[7] = in_data.coord_7;

  // The 16-bit field is taken as raw bits and then read as a signed value of
  // the storage width, so a narrower store drops the upper bits and a wider
  // store sees only non-negative values.
  always_comb begin
    if (dims_r == '0) begin
      dims_act = DIMS_W'(1);
    end else if (dims_r > DIMS_W'(MAX_DIMS)) begin
      dims_act = DIMS_W'(MAX_DIMS);
    end else begin
      dims_act = dims_r;
    end
  end

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
    assign coord_cvt[d] = COORD_BITS'($unsigned(in_coord[d]));
    assign dim_en[d]    = (dims_act > DIMS_W'(d));

    // The query is held for the whole store walk.
    always_ff @(posedge clk) begin
      if (start) begin
        q_r[d] <= coord_cvt[d];
      end
    end
  end

  // Class ids are stored reduced modulo the class count; the table is fixed at
  // elaboration.
  for (genvar i = 0; i < l1nn_pkg::CLASS_CODES; i++) begin : g_cls
    assign cls_tbl[i] = LABEL_W'(i % CLASS_COUNT);
  end
  assign wr_label = cls_tbl[in_data.class_id];

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid & in_ready;
  assign scan_last = ((CNT_W'(scan_addr_r) + CNT_W'(1)) == count_r);

  // Sequencer: add, clear, unused codes and an empty-store classify end at once;
  // a classify walks entries 0 to count-1 into the chain, then awaits the search.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_addr_nxt = scan_addr_r;
    op_nxt        = op_r;
    full_nxt      = full_r;
    wr_en         = 1'b0;
    start         = 1'b0;
    out_load      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_data.operation;
          full_nxt  = 1'b0;
          state_nxt = ST_DONE;
          case (in_data.operation)
            l1nn_pkg::OP_ADD: begin
              if (count_r < CNT_W'(CAPACITY)) begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end else begin
                full_nxt = 1'b1;
              end
            end
            l1nn_pkg::OP_CLASSIFY: begin
              start         = 1'b1;
              scan_addr_nxt = '0;
              // An empty store answers with no match straight away.
              if (count_r != '0) begin
                state_nxt = ST_SCAN;
              end
            end
            l1nn_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_DRAIN;
        end else begin
          scan_addr_nxt = scan_addr_r + ADDR_W'(1);
        end
      end
      ST_DRAIN: begin
        if (best_st.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result assembly: only a classify reports class and distance, only an add
  // can report a full store.
  always_comb begin
    out_nxt            = '0;
    out_nxt.store_full = full_r;
    if (op_r == l1nn_pkg::OP_CLASSIFY) begin
      out_nxt.match_found   = best_st.match;
      out_nxt.best_class    = CW'(best_cls);
      out_nxt.best_distance = best_dist;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Configuration register. Writes outside the register list are ignored.
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[l1nn_pkg::PADDR_W-1:2];
  assign prdata  = (reg_idx == l1nn_pkg::REG_DIMS) ? PDW'(dims_r) : '0;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      dims_r      <= l1nn_pkg::DIMS_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && (reg_idx == l1nn_pkg::REG_DIMS)) begin
        dims_r <= pwdata[DIMS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_addr_r <= scan_addr_nxt;
    op_r        <= op_nxt;
    full_r      <= full_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Head of the distance chain: one entry address per cycle during the walk.
  assign ctl_ch[0].valid = (state_r == ST_SCAN);
  assign ctl_ch[0].last  = scan_last;
  assign addr_ch[0]      = scan_addr_r;
  assign sum_ch[0]       = '0;

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_cell
    l1nn_cell #(
      .COORD_BITS(COORD_BITS),
      .CAPACITY  (CAPACITY),
      .ADDR_W    (ADDR_W),
      .SUM_W     (SUM_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .wr_en  (wr_en),
      .wr_addr(count_r[ADDR_W-1:0]),
      .wr_data(coord_cvt[d]),
      .q      (q_r[d]),
      .dim_en (dim_en[d]),
      .ctl_i  (ctl_ch[d]),
      .addr_i (addr_ch[d]),
      .sum_i  (sum_ch[d]),
      .ctl_o  (ctl_ch[d+1]),
      .addr_o (addr_ch[d+1]),
      .sum_o  (sum_ch[d+1])
    );
  end

  l1nn_best #(
    .CAPACITY(CAPACITY),
    .ADDR_W  (ADDR_W),
    .SUM_W   (SUM_W),
    .LABEL_W (LABEL_W)
  ) u_best (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .wr_en       (wr_en),
    .wr_addr     (count_r[ADDR_W-1:0]),
    .wr_label    (wr_label),
    .ctl_i       (ctl_ch[MAX_DIMS]),
    .addr_i      (addr_ch[MAX_DIMS]),
    .sum_i       (sum_ch[MAX_DIMS]),
    .status_o    (best_st),
    .best_class_o(best_cls),
    .best_dist_o (best_dist)
  );

endmodule

[rtl/l1nn_checker.sv]
// Port level checker of the L1 nearest neighbor classifier, bound to the top.
// Uses l1nn_pkg and the assertion macros of the block's header.
`include "l1_nearest_neighbor_classifier_unit_assert.svh"

module l1nn_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input l1nn_pkg::in_item_t           in_data,
  input logic                         out_valid,
  input logic                         out_ready,
  input l1nn_pkg::out_item_t          out_data,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [l1nn_pkg::PADDR_W-1:0] paddr,
  input logic [l1nn_pkg::PDATA_W-1:0] pwdata,
  input logic [l1nn_pkg::PDATA_W-1:0] prdata,
  input logic                         pready
);

  // A result that waits for the receiver is held unchanged.
  `L1NN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // Without a match the class and distance fields are zero.
  `L1NN_ASSERT_NOW(a_nomatch_zero, out_valid && !out_data.match_found, out_data.best_class == '0 && out_data.best_distance == '0, "nonzero class or distance without a match")

  // A dropped add and a classify match never appear in one result.
  `L1NN_ASSERT_NOW(a_full_excl, out_valid && out_data.store_full, !out_data.match_found, "store full reported together with a match")

  // A write to dims_in_use reads back on the next cycle.
  `L1NN_ASSERT_NEXT(a_cfg_readback, psel && penable && pwrite && pready && paddr[2] == 1'b0, paddr[2] != 1'b0 || prdata[3:0] == $past(pwdata[3:0]), "dims_in_use did not read back")

endmodule

bind l1_nearest_neighbor_classifier_unit l1nn_checker u_l1nn_checker (.*);
